// File: rtl/core/tlbc_pkg.sv
// Shared types and constants for the clock-replacement TLB core.
// No dependencies; used by tlbc_ctrl and tlb_lookup_clock_replace_core.

package tlbc_pkg;

    // Width and reset value of the entries-in-use register.
    localparam int CFG_W     = 5;
    localparam int CFG_RESET = 16;

    // Result flags that travel from the controller to the output stage.
    typedef struct packed {
        logic hit;
        logic dirty_mark;
    } tlbc_res_flags_t;

endpackage

// File: rtl/core/tlbc_mem.sv
// Entry store of the TLB: one write port and one read port with registered data.
// No dependencies.

module tlbc_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 41
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/core/tlbc_ctrl.sv
// Lookup and replacement sequencer of the TLB: scans the entry store, keeps the
// valid and used bits in flip-flops and writes the chosen entry back. Uses tlbc_pkg.

module tlbc_ctrl #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_BITS   = 20
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Access request.
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [PAGE_BITS-1:0]                 in_page,
    input  logic                                 in_write,
    input  logic [PAGE_BITS-1:0]                 in_walk,
    // Number of entries searched, already saturated.
    input  logic [$clog2(TLB_ENTRIES+1)-1:0]     active_cnt,
    // Result toward the output register.
    input  logic                                 out_free,
    output logic                                 res_valid,
    output logic [PAGE_BITS-1:0]                 res_frame,
    output logic [$clog2(TLB_ENTRIES)-1:0]       res_idx,
    output tlbc_pkg::tlbc_res_flags_t            res_flags,
    // Entry store port.
    output logic                                 mem_we,
    output logic [$clog2(TLB_ENTRIES)-1:0]       mem_waddr,
    output logic [2*PAGE_BITS:0]                 mem_wdata,
    output logic [$clog2(TLB_ENTRIES)-1:0]       mem_raddr,
    input  logic [2*PAGE_BITS:0]                 mem_rdata
);

    localparam int IDX_W = $clog2(TLB_ENTRIES);
    localparam int CNT_W = $clog2(TLB_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_HIT  = 2'd2;
    localparam logic [1:0] ST_FILL = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [PAGE_BITS-1:0]   page_reg, page_next;
    logic                   write_reg, write_next;
    logic [PAGE_BITS-1:0]   walk_reg, walk_next;
    logic [CNT_W-1:0]       iss_reg, iss_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   inv_fnd_reg, inv_fnd_next;
    logic [IDX_W-1:0]       inv_idx_reg, inv_idx_next;
    logic                   unu_fnd_reg, unu_fnd_next;
    logic [IDX_W-1:0]       unu_idx_reg, unu_idx_next;
    logic [IDX_W-1:0]       sel_reg, sel_next;
    logic [PAGE_BITS-1:0]   hit_frame_reg, hit_frame_next;
    logic [TLB_ENTRIES-1:0] valid_reg, valid_next;
    logic [TLB_ENTRIES-1:0] used_reg, used_next;

    logic                   issue;
    logic                   hit_now;
    logic [IDX_W-1:0]       fill_sel;
    logic [CNT_W-1:0]       clear_lim;
    logic [PAGE_BITS-1:0]   rd_page;
    logic [PAGE_BITS-1:0]   rd_frame;

    assign rd_page   = mem_rdata[PAGE_BITS-1:0];
    assign rd_frame  = mem_rdata[2*PAGE_BITS-1:PAGE_BITS];
    assign in_ready  = (state_reg == ST_IDLE);
    assign issue     = (iss_reg < active_cnt);
    assign mem_raddr = iss_reg[IDX_W-1:0];

    // A compare hits when the entry read last cycle is valid and holds the page.
    assign hit_now = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_page == page_reg);

    // Victim: first invalid entry, else first entry with a clear used bit, else entry 0.
    always_comb begin
        if (inv_fnd_reg) begin
            fill_sel = inv_idx_reg;
        end else if (unu_fnd_reg) begin
            fill_sel = unu_idx_reg;
        end else begin
            fill_sel = '0;
        end
    end

    // The clock sweep clears the used bits of all entries it passes.
    assign clear_lim = unu_fnd_reg ? CNT_W'(unu_idx_reg) : active_cnt;

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        page_next      = page_reg;
        write_next     = write_reg;
        walk_next      = walk_reg;
        iss_next       = iss_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        inv_fnd_next   = inv_fnd_reg;
        inv_idx_next   = inv_idx_reg;
        unu_fnd_next   = unu_fnd_reg;
        unu_idx_next   = unu_idx_reg;
        sel_next       = sel_reg;
        hit_frame_next = hit_frame_reg;
        valid_next     = valid_reg;
        used_next      = used_reg;
        mem_we         = 1'b0;
        mem_waddr      = sel_reg;
        mem_wdata      = {write_reg, hit_frame_reg, page_reg};
        res_valid      = 1'b0;
        res_frame      = hit_frame_reg;
        res_idx        = sel_reg;
        res_flags.hit        = 1'b1;
        res_flags.dirty_mark = write_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    page_next    = in_page;
                    write_next   = in_write;
                    walk_next    = in_walk;
                    iss_next     = '0;
                    cmp_vld_next = 1'b0;
                    inv_fnd_next = 1'b0;
                    unu_fnd_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Issue the next read and note the first invalid and first unused entry.
                cmp_vld_next = issue;
                cmp_idx_next = iss_reg[IDX_W-1:0];
                if (issue) begin
                    iss_next = iss_reg + CNT_W'(1);
                    if (!valid_reg[iss_reg[IDX_W-1:0]] && !inv_fnd_reg) begin
                        inv_fnd_next = 1'b1;
                        inv_idx_next = iss_reg[IDX_W-1:0];
                    end
                    if (!used_reg[iss_reg[IDX_W-1:0]] && !unu_fnd_reg) begin
                        unu_fnd_next = 1'b1;
                        unu_idx_next = iss_reg[IDX_W-1:0];
                    end
                end
                if (hit_now) begin
                    sel_next       = cmp_idx_reg;
                    hit_frame_next = rd_frame;
                    state_next     = ST_HIT;
                end else if (!issue) begin
                    state_next = ST_FILL;
                end
            end

            ST_HIT: begin
                // Refresh used and dirty of the hit entry.
                if (out_free) begin
                    mem_we              = 1'b1;
                    used_next[sel_reg]  = 1'b1;
                    res_valid           = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            ST_FILL: begin
                // Install the walker frame in the victim entry.
                mem_waddr            = fill_sel;
                mem_wdata            = {write_reg, walk_reg, page_reg};
                res_frame            = walk_reg;
                res_idx              = fill_sel;
                res_flags.hit        = 1'b0;
                if (out_free) begin
                    mem_we = 1'b1;
                    if (!inv_fnd_reg) begin
                        for (int k = 0; k < TLB_ENTRIES; k++) begin
                            if (CNT_W'(k) < clear_lim) begin
                                used_next[k] = 1'b0;
                            end
                        end
                    end
                    used_next[fill_sel]  = 1'b1;
                    valid_next[fill_sel] = 1'b1;
                    res_valid            = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and per-entry flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            used_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            used_reg    <= used_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    // Transaction and scan payload.
    always_ff @(posedge aclk) begin
        page_reg      <= page_next;
        write_reg     <= write_next;
        walk_reg      <= walk_next;
        iss_reg       <= iss_next;
        cmp_idx_reg   <= cmp_idx_next;
        inv_fnd_reg   <= inv_fnd_next;
        inv_idx_reg   <= inv_idx_next;
        unu_fnd_reg   <= unu_fnd_next;
        unu_idx_reg   <= unu_idx_next;
        sel_reg       <= sel_next;
        hit_frame_reg <= hit_frame_next;
    end

    // An accepted transaction always starts a scan.
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_SCAN))
        else $error("accepted transaction did not start a scan");

    // A result is only produced when the output register can take it.
    a_res_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result produced while output register is full");

    // A committed fill leaves its entry valid and used.
    a_fill_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL && out_free) |=>
            (valid_reg[$past(fill_sel)] && used_reg[$past(fill_sel)]))
        else $error("filled entry not marked valid and used");

endmodule

// File: rtl/core/tlb_lookup_clock_replace_core.sv
// Top level of the fully associative TLB with clock replacement.
// Depends on tlbc_pkg, tlbc_mem and tlbc_ctrl.
//
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  access: page, write flag, walker frame
// m_*       out        m_tvalid/m_tready  result: frame, hit, entry, dirty, used
// cfg_*     in         cfg_wr_en          entries_in_use register
//
// A hit ends the scan at the hit entry; a miss scans all n entries, n being
// the entries in use. The single read port of the entry store, one entry per
// cycle, paces the scan.
// Reset clears the valid and used flip-flops at once.
// A result waiting in the output register holds the sequencer before write-back.

module tlb_lookup_clock_replace_core #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_BITS   = 20
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // s_tdata: virtual_page, walk_frame, zero fill.
    input  logic [((2*PAGE_BITS+7)/8)*8-1:0]              s_tdata,
    // s_tuser: is_write.
    input  logic                                          s_tuser,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // m_tdata: frame, entry_index, page_dirty_mark, page_used_mark, zero fill.
    output logic [((PAGE_BITS+$clog2(TLB_ENTRIES)+2+7)/8)*8-1:0] m_tdata,
    // m_tuser: hit.
    output logic                                          m_tuser,
    input  logic                                          cfg_wr_en,
    input  logic [tlbc_pkg::CFG_W-1:0]                    cfg_wr_data
);

    localparam int IDX_W   = $clog2(TLB_ENTRIES);
    localparam int CNT_W   = $clog2(TLB_ENTRIES + 1);
    localparam int ENT_W   = 2 * PAGE_BITS + 1;
    localparam int ODAT_W  = PAGE_BITS + IDX_W + 2;
    localparam int OBUS_W  = ((ODAT_W + 7) / 8) * 8;

    logic [tlbc_pkg::CFG_W-1:0] cfg_reg;
    logic [CNT_W-1:0]           active_cnt;
    logic                       out_free;
    logic                       res_valid;
    logic [PAGE_BITS-1:0]       res_frame;
    logic [IDX_W-1:0]           res_idx;
    tlbc_pkg::tlbc_res_flags_t  res_flags;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [ENT_W-1:0]           mem_wdata;
    logic [IDX_W-1:0]           mem_raddr;
    logic [ENT_W-1:0]           mem_rdata;
    logic                       m_tvalid_reg;
    logic [OBUS_W-1:0]          m_tdata_reg;
    logic                       m_tuser_reg;

    // Entries-in-use register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= tlbc_pkg::CFG_W'(tlbc_pkg::CFG_RESET);
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // Saturate the register to the number of entries that exist.
    always_comb begin
        if (int'(cfg_reg) > TLB_ENTRIES) begin
            active_cnt = CNT_W'(TLB_ENTRIES);
        end else begin
            active_cnt = CNT_W'(cfg_reg);
        end
    end

    tlbc_mem #(
        .DEPTH (TLB_ENTRIES),
        .WIDTH (ENT_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    tlbc_ctrl #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_BITS   (PAGE_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_page    (s_tdata[PAGE_BITS-1:0]),
        .in_write   (s_tuser),
        .in_walk    (s_tdata[2*PAGE_BITS-1:PAGE_BITS]),
        .active_cnt (active_cnt),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res_frame  (res_frame),
        .res_idx    (res_idx),
        .res_flags  (res_flags),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // Output register: free when empty or when its transaction completes now.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= OBUS_W'({1'b1, res_flags.dirty_mark, res_idx, res_frame});
            m_tuser_reg <= res_flags.hit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: tb/tb_tlb_lookup_clock_replace_core.sv
// Self-checking testbench for tlb_lookup_clock_replace_core, the clock-replacement TLB.
// Depends on tlbc_pkg and the core; a built-in TLB model predicts every result transaction.

module tb_tlb_lookup_clock_replace_core;

    localparam int ENTRIES    = 16;
    localparam int PAGE_W     = 20;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 40;
    localparam int RANDOM_ITEMS = 1600;

    typedef struct {
        logic [PAGE_W-1:0] frame;
        logic              hit;
        logic [3:0]        entry;
        logic              dirty;
        logic              used;
    } tlb_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [39:0]         s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;
    logic                m_tuser;
    logic                cfg_wr_en;
    logic [tlbc_pkg::CFG_W-1:0] cfg_wr_data;

    // Shadow copy of the TLB state and the entries-in-use register.
    logic                tlb_valid [ENTRIES];
    logic [PAGE_W-1:0]   tlb_page  [ENTRIES];
    logic [PAGE_W-1:0]   tlb_frame [ENTRIES];
    logic                tlb_used  [ENTRIES];
    logic                tlb_dirty [ENTRIES];
    logic [tlbc_pkg::CFG_W-1:0] active_entries;

    tlb_result_t         pending_results[$];
    int                  fail_count;
    int                  idle_cycles;
    bit                  no_stall;

    // Page pool that keeps random traffic hitting the TLB often.
    logic [PAGE_W-1:0]   page_pool[24];
    int                  pool_size;

    tlb_lookup_clock_replace_core #(
        .TLB_ENTRIES(ENTRIES),
        .PAGE_BITS  (PAGE_W)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Look up one access, install it on a miss, and return the result it should produce.
    function automatic tlb_result_t translate_access(input logic [PAGE_W-1:0] page,
                                                     input logic wr,
                                                     input logic [PAGE_W-1:0] walk);
        int          n;
        int          k;
        int          sel;
        bit          found;
        bit          placed;
        tlb_result_t r;
        n = (active_entries > ENTRIES) ? ENTRIES : int'(active_entries);
        sel = 0;
        found = 1'b0;
        placed = 1'b0;
        for (k = 0; k < n && !found; k++) begin
            if (tlb_valid[k] && tlb_page[k] == page) begin
                found = 1'b1;
                sel = k;
            end
        end
        if (found) begin
            r.frame = tlb_frame[sel];
        end else begin
            r.frame = walk;
            for (k = 0; k < n && !placed; k++) begin
                if (!tlb_valid[k]) begin
                    sel = k;
                    placed = 1'b1;
                end
            end
            // Clock sweep: clear used bits until an unused entry turns up.
            for (k = 0; k < n && !placed; k++) begin
                if (!tlb_used[k]) begin
                    sel = k;
                    placed = 1'b1;
                end else begin
                    tlb_used[k] = 1'b0;
                end
            end
            if (!placed) begin
                sel = 0;
            end
            tlb_valid[sel] = 1'b1;
            tlb_page[sel]  = page;
            tlb_frame[sel] = walk;
        end
        tlb_used[sel]  = 1'b1;
        tlb_dirty[sel] = wr;
        r.hit   = found;
        r.entry = sel[3:0];
        r.dirty = wr;
        r.used  = 1'b1;
        return r;
    endfunction

    // Send one access transaction and record the result it should produce.
    task automatic send_access(input logic [PAGE_W-1:0] page, input logic wr,
                               input logic [PAGE_W-1:0] walk);
        if (!no_stall && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tdata  <= {walk, page};
        s_tuser  <= wr;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(translate_access(page, wr, walk));
        @(negedge aclk);
    endtask

    // Write the entries-in-use register once the core has gone idle.
    task automatic set_entries(input logic [tlbc_pkg::CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        active_entries = value;
    endtask

    // Fill a small TLB, hit with both write flags, then force sweeps.
    task automatic test_fill_and_sweep();
        set_entries(tlbc_pkg::CFG_W'(4));
        send_access(20'h00000, 1'b0, 20'h00000);
        send_access(20'hFFFFF, 1'b1, 20'hFFFFF);
        send_access(20'h55555, 1'b0, 20'hAAAAA);
        send_access(20'hAAAAA, 1'b1, 20'h55555);
        send_access(20'h00000, 1'b1, 20'h12345);
        send_access(20'hFFFFF, 1'b0, 20'h00000);
        // Every entry is used, so the sweep clears them all and takes entry 0.
        send_access(20'h13579, 1'b0, 20'h2468A);
        send_access(20'h2468A, 1'b1, 20'h13579);
    endtask

    // Zero entries, too many entries, and a single entry.
    task automatic test_entry_limits();
        set_entries(tlbc_pkg::CFG_W'(0));
        send_access(20'h00123, 1'b1, 20'h0F0F0);
        send_access(20'h00123, 1'b0, 20'hF0F0F);
        set_entries(tlbc_pkg::CFG_W'(31));
        send_access(20'h00123, 1'b0, 20'h11111);
        send_access(20'h80000, 1'b1, 20'h7FFFF);
        set_entries(tlbc_pkg::CFG_W'(1));
        send_access(20'h00001, 1'b0, 20'h00002);
        send_access(20'h00001, 1'b1, 20'h00003);
    endtask

    // A page left outside a shrunken window gets a second copy; the lower one must win.
    task automatic test_duplicate_pages();
        set_entries(tlbc_pkg::CFG_W'(16));
        send_access(20'hC0DE5, 1'b1, 20'hBEEF0);
        set_entries(tlbc_pkg::CFG_W'(2));
        send_access(20'hC0DE5, 1'b0, 20'h0BEEF);
        set_entries(tlbc_pkg::CFG_W'(16));
        send_access(20'hC0DE5, 1'b1, 20'h00000);
        send_access(20'h00000, 1'b0, 20'hFFFFF);
    endtask

    // Random traffic over several register settings, mostly drawn from a page pool.
    task automatic test_random_traffic(input int count);
        logic [tlbc_pkg::CFG_W-1:0] settings[8];
        int               phase;
        int               i;
        int               n;
        logic [PAGE_W-1:0] page;
        settings = '{tlbc_pkg::CFG_W'(16), tlbc_pkg::CFG_W'(2), tlbc_pkg::CFG_W'(31),
                     tlbc_pkg::CFG_W'(0), tlbc_pkg::CFG_W'(16), tlbc_pkg::CFG_W'(17),
                     tlbc_pkg::CFG_W'(1), tlbc_pkg::CFG_W'(8)};
        settings[7] = tlbc_pkg::CFG_W'($urandom_range(3, 15));
        for (phase = 0; phase < 8; phase++) begin
            set_entries(settings[phase]);
            n = (settings[phase] > ENTRIES) ? ENTRIES : int'(settings[phase]);
            pool_size = n + $urandom_range(1, 6);
            for (i = 0; i < pool_size; i++) begin
                page_pool[i] = PAGE_W'($urandom);
            end
            page_pool[0] = '0;
            page_pool[pool_size-1] = '1;
            // One phase runs with neither side stalling.
            no_stall = (phase == 4);
            for (i = 0; i < count / 8; i++) begin
                if ($urandom_range(99) < 80) begin
                    page = page_pool[$urandom_range(pool_size - 1)];
                end else begin
                    page = PAGE_W'($urandom);
                end
                send_access(page, 1'($urandom), PAGE_W'($urandom));
            end
            no_stall = 1'b0;
        end
    endtask

    // Result sink back-pressure.
    always @(negedge aclk) begin
        m_tready <= no_stall || ($urandom_range(99) >= 6);
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        tlb_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: %h hit %b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[19:0] !== exp_r.frame) begin
                    $error("frame mismatch: expected %h, actual %h", exp_r.frame, m_tdata[19:0]);
                    fail_count++;
                end
                if (m_tuser !== exp_r.hit) begin
                    $error("hit mismatch: expected %b, actual %b", exp_r.hit, m_tuser);
                    fail_count++;
                end
                if (m_tdata[23:20] !== exp_r.entry) begin
                    $error("entry_index mismatch: expected %0d, actual %0d",
                           exp_r.entry, m_tdata[23:20]);
                    fail_count++;
                end
                if (m_tdata[24] !== exp_r.dirty) begin
                    $error("page_dirty_mark mismatch: expected %b, actual %b",
                           exp_r.dirty, m_tdata[24]);
                    fail_count++;
                end
                if (m_tdata[25] !== exp_r.used) begin
                    $error("page_used_mark mismatch: expected %b, actual %b",
                           exp_r.used, m_tdata[25]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction or register write happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence.
    initial begin
        int k;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        no_stall    = 1'b0;
        for (k = 0; k < ENTRIES; k++) begin
            tlb_valid[k] = 1'b0;
            tlb_page[k]  = '0;
            tlb_frame[k] = '0;
            tlb_used[k]  = 1'b0;
            tlb_dirty[k] = 1'b0;
        end
        active_entries = tlbc_pkg::CFG_W'(tlbc_pkg::CFG_RESET);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_fill_and_sweep();
        test_entry_limits();
        test_duplicate_pages();
        test_random_traffic(RANDOM_ITEMS);

        // Drain the outstanding results, then give the core time to settle.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
